// ----- src/kvi_pkg.sv -----
`default_nettype none
package kvi_pkg;

    localparam int MAX_KEYFRAMES = 16;
    localparam int KEY_AW        = 4;
    localparam int POS_DEPTH     = 2 * MAX_KEYFRAMES;
    localparam int POS_AW        = 5;
    localparam int COUNT_W       = 5;
    localparam int KEY_W         = 16;
    localparam int COMP_W        = 32;
    localparam int POS_W         = 64;
    localparam int IN_TDATA_W    = 168;
    localparam int OUT_TDATA_W   = 128;
    localparam int CFG_AW        = 3;
    localparam int CFG_DW        = 32;

    // shared divider: magnitude of a 50-bit product, 4 quotient bits per cycle
    localparam int DIV_W         = 52;
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_ITERS     = DIV_W / DIV_STEP_BITS;
    localparam int DEN_W         = 16;
    localparam int PROD_W        = 50;
    localparam int QMAG_W        = 34;
    localparam int SUM_W         = 35;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register index taken from byte address bit 2
    localparam logic REG_KEYFRAME_COUNT = 1'b0;

    typedef struct packed {
        logic                     func;
        logic [KEY_AW-1:0]        slot;
        logic [KEY_W-1:0]         key_value;
        logic signed [COMP_W-1:0] pos_x;
        logic signed [COMP_W-1:0] pos_y;
        logic signed [COMP_W-1:0] pos_z;
        logic signed [COMP_W-1:0] pos_w;
        logic [KEY_W-1:0]         fraction;
    } item_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD1,
        B_LOAD2,
        B_QSTART,
        B_KEY0,
        B_SCAN,
        B_POSA,
        B_POSD,
        B_MUL,
        B_DSTART,
        B_DIV,
        B_OUT
    } back_state_t;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [DEN_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

// ----- src/kvi_ram.sv -----
`default_nettype none
module kvi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/kvi_front.sv -----
`default_nettype none
module kvi_front
    import kvi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    output item_t                      item,
    output logic                       item_valid,
    input  wire logic                  item_pop
);

    item_t       q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    item_t       in_item;
    logic        push;
    logic        pop;

    // unpack the incoming transaction
    always_comb
    begin
        in_item.func      = s_axis_tuser;
        in_item.slot      = s_axis_tdata[3:0];
        in_item.key_value = s_axis_tdata[19:4];
        in_item.pos_x     = s_axis_tdata[51:20];
        in_item.pos_y     = s_axis_tdata[83:52];
        in_item.pos_z     = s_axis_tdata[115:84];
        in_item.pos_w     = s_axis_tdata[147:116];
        in_item.fraction  = s_axis_tdata[163:148];
    end

    assign s_axis_tready = (fill_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign item_valid    = (fill_reg != 2'd0);
    assign pop           = item_pop && item_valid;
    assign item          = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ----- src/kvi_div.sv -----
`default_nettype none
module kvi_div
    import kvi_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    localparam int ITER_W = $clog2(DIV_ITERS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DEN_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]  dq_reg, dq_next;
    logic [DEN_W-1:0]  den_reg, den_next;

    always_comb
    begin
        logic [DEN_W:0]   r;
        logic [DIV_W-1:0] q;
        r         = rem_reg;
        q         = dq_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            den_next  = req.divisor;
            r         = '0;
            q         = req.dividend;
        end
        else if (busy_reg)
        begin
            // restoring steps, most significant dividend bit first
            for (int k = 0; k < DIV_STEP_BITS; k++)
            begin
                r = {r[DEN_W-1:0], q[DIV_W-1]};
                q = {q[DIV_W-2:0], 1'b0};
                if (r >= {1'b0, den_reg})
                begin
                    r    = r - {1'b0, den_reg};
                    q[0] = 1'b1;
                end
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(DIV_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        rem_next = r;
        dq_next  = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

endmodule
`default_nettype wire

// ----- src/kvi_back.sv -----
`default_nettype none
module kvi_back
    import kvi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire item_t                  item,
    input  wire logic                   item_valid,
    output logic                        item_pop,
    input  wire logic [COUNT_W-1:0]     keyframe_count,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    back_state_t state_reg, state_next;

    item_t                    cur_reg, cur_next;
    logic [KEY_AW-1:0]        idx_reg, idx_next;
    logic [KEY_W-1:0]         kprev_reg, kprev_next;
    logic [KEY_W-1:0]         num_reg, num_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [1:0]               pc_reg, pc_next;
    logic [1:0]               comp_reg, comp_next;
    logic signed [COMP_W-1:0] v0_reg [4];
    logic signed [COMP_W-1:0] v1_reg [4];
    logic signed [COMP_W-1:0] res_reg [4];
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]   out_data_reg, out_data_next;

    logic [COUNT_W-1:0]       count_eff;
    logic [COUNT_W-1:0]       idx_plus2;
    logic                     key_we;
    logic [KEY_AW-1:0]        key_waddr;
    logic [KEY_AW-1:0]        key_raddr;
    logic [KEY_W-1:0]         key_rdata;
    logic                     pos_we;
    logic [POS_AW-1:0]        pos_waddr;
    logic [POS_W-1:0]         pos_wdata;
    logic [POS_AW-1:0]        pos_raddr;
    logic [POS_W-1:0]         pos_rdata;
    logic [POS_AW-1:0]        pos_base;
    logic                     bracket;
    logic                     pos_capture;
    logic                     res_we;
    logic signed [COMP_W-1:0] res_value;
    logic                     out_free;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;
    logic [PROD_W-1:0]        prod_mag;
    logic signed [QMAG_W-1:0] q_signed;
    logic signed [SUM_W-1:0]  sum;

    kvi_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYFRAMES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (cur_reg.key_value),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    kvi_ram #(.WIDTH(POS_W), .DEPTH(POS_DEPTH)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    kvi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign count_eff = (keyframe_count > COUNT_W'(MAX_KEYFRAMES)) ?
                       COUNT_W'(MAX_KEYFRAMES) : keyframe_count;
    assign idx_plus2 = {1'b0, idx_reg} + COUNT_W'(2);
    assign bracket   = (cur_reg.fraction >= kprev_reg) && (cur_reg.fraction <= key_rdata);
    assign pos_base  = {idx_reg, 1'b0};
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // signed quotient, dropped entirely for a zero-width segment
    always_comb
    begin
        logic [QMAG_W-1:0] qmag;
        qmag     = div_rsp.quotient[QMAG_W-1:0];
        q_signed = '0;
        if (den_reg != '0)
        begin
            q_signed = prod_reg[PROD_W-1] ? -$signed(qmag) : $signed(qmag);
        end
        sum = SUM_W'(v0_reg[comp_reg]) + SUM_W'(q_signed);
        if (sum > SUM_W'(32'sh7fffffff))
        begin
            res_value = 32'sh7fffffff;
        end
        else if (sum < -SUM_W'(33'sh080000000))
        begin
            res_value = 32'sh80000000;
        end
        else
        begin
            res_value = sum[COMP_W-1:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (item.func == FUNC_QUERY) ? B_QSTART : B_LOAD1;
                end
            end
            B_LOAD1:  state_next = B_LOAD2;
            B_LOAD2:  state_next = B_IDLE;
            B_QSTART: state_next = (count_eff < COUNT_W'(2)) ? B_IDLE : B_KEY0;
            B_KEY0:   state_next = B_SCAN;
            B_SCAN:
            begin
                if (bracket)
                begin
                    state_next = B_POSA;
                end
                else if (idx_plus2 >= count_eff)
                begin
                    state_next = B_IDLE;
                end
            end
            B_POSA:   state_next = B_POSD;
            B_POSD:   state_next = (pc_reg == 2'd3) ? B_MUL : B_POSA;
            B_MUL:    state_next = B_DSTART;
            B_DSTART: state_next = B_DIV;
            B_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (comp_reg == 2'd3) ? B_OUT : B_MUL;
                end
            end
            B_OUT:    state_next = out_free ? B_IDLE : B_OUT;
            default:  state_next = B_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        cur_next         = cur_reg;
        idx_next         = idx_reg;
        kprev_next       = kprev_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        pc_next          = pc_reg;
        comp_next        = comp_reg;
        prod_next        = prod_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        item_pop         = 1'b0;
        key_we           = 1'b0;
        key_waddr        = cur_reg.slot;
        key_raddr        = '0;
        pos_we           = 1'b0;
        pos_waddr        = {cur_reg.slot, 1'b0};
        pos_wdata        = {cur_reg.pos_y, cur_reg.pos_x};
        pos_raddr        = pos_base + POS_AW'(pc_reg);
        pos_capture      = 1'b0;
        res_we           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'(prod_mag);
        div_req.divisor  = den_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    cur_next = item;
                end
            end
            B_LOAD1:
            begin
                key_we = 1'b1;
                pos_we = 1'b1;
            end
            B_LOAD2:
            begin
                pos_we    = 1'b1;
                pos_waddr = {cur_reg.slot, 1'b1};
                pos_wdata = {cur_reg.pos_w, cur_reg.pos_z};
            end
            B_QSTART:
            begin
                key_raddr = '0;
            end
            B_KEY0:
            begin
                kprev_next = key_rdata;
                key_raddr  = KEY_AW'(1);
                idx_next   = '0;
            end
            B_SCAN:
            begin
                key_raddr = idx_plus2[KEY_AW-1:0];
                if (bracket)
                begin
                    num_next = cur_reg.fraction - kprev_reg;
                    den_next = key_rdata - kprev_reg;
                    pc_next  = '0;
                end
                else
                begin
                    kprev_next = key_rdata;
                    idx_next   = idx_reg + 1'b1;
                end
            end
            B_POSA:
            begin
                pos_raddr = pos_base + POS_AW'(pc_reg);
            end
            B_POSD:
            begin
                pos_capture = 1'b1;
                pc_next     = pc_reg + 1'b1;
                comp_next   = '0;
            end
            B_MUL:
            begin
                prod_next = (PROD_W'(v1_reg[comp_reg]) - PROD_W'(v0_reg[comp_reg]))
                            * $signed({1'b0, num_reg});
            end
            B_DSTART:
            begin
                div_req.start = 1'b1;
            end
            B_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_we    = 1'b1;
                    comp_next = comp_reg + 1'b1;
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        kprev_reg    <= kprev_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        pc_reg       <= pc_next;
        comp_reg     <= comp_next;
        prod_reg     <= prod_next;
        out_data_reg <= out_data_next;
        if (pos_capture)
        begin
            case (pc_reg)
                2'd0:
                begin
                    v0_reg[0] <= pos_rdata[31:0];
                    v0_reg[1] <= pos_rdata[63:32];
                end
                2'd1:
                begin
                    v0_reg[2] <= pos_rdata[31:0];
                    v0_reg[3] <= pos_rdata[63:32];
                end
                2'd2:
                begin
                    v1_reg[0] <= pos_rdata[31:0];
                    v1_reg[1] <= pos_rdata[63:32];
                end
                default:
                begin
                    v1_reg[2] <= pos_rdata[31:0];
                    v1_reg[3] <= pos_rdata[63:32];
                end
            endcase
        end
        if (res_we)
        begin
            res_reg[comp_reg] <= res_value;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- src/keyframe_vec4_interpolator.sv -----
// keyframe_vec4_interpolator: piecewise-linear interpolation over a keyframe table
//
// input stream (s_axis_*): tuser selects load (0) or query (1); tdata carries the
// slot, key and x/y/z/w position of a load, or the fraction of a query
// output stream (m_axis_*): one transaction per query that lands inside a segment,
// carrying the interpolated x/y/z/w, saturated to signed Q16.16
// apb port: register 0 (byte address 0) is keyframe_count, values above 16 clamp
//
// a two-entry queue takes transactions while the back end works
// load: pop, key + x/y write, z/w write
// query: start steps, one step per key pair scanned (up to 15), 4 position reads
//   + 4 components x (multiply, start and run of the shared radix-16 divider)
//   + an output step
// a query with fewer than two keys or no bracketing pair returns nothing
// reset clears the queue, the sequencer, the output register and keyframe_count;
// table contents are undefined until loaded
// a stalled receiver holds the result in the output register; the back end
// waits in its output step and the queue keeps accepting until full
`default_nettype none
module keyframe_vec4_interpolator
    import kvi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // apb configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_AW-1:0]      paddr,
    input  wire logic [CFG_DW-1:0]      pwdata,
    output logic      [CFG_DW-1:0]      prdata,
    output logic                        pready,
    // input stream
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // slot[3:0], key_value[19:4], pos_x[51:20], pos_y[83:52], pos_z[115:84],
    // pos_w[147:116], fraction[163:148], zero pad [167:164]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // func: 0 load, 1 query
    input  wire logic                   s_axis_tuser,
    // output stream
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               cfg_write;
    item_t              item;
    logic               item_valid;
    logic               item_pop;

    // configuration register, written on the apb access cycle
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_write && (paddr[2] == REG_KEYFRAME_COUNT))
        begin
            count_next = pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_KEYFRAME_COUNT)
        begin
            prdata = CFG_DW'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // front end: accept and queue transactions
    kvi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    // back end: table writes, segment scan, interpolation
    kvi_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .item_valid     (item_valid),
        .item_pop       (item_pop),
        .keyframe_count (count_reg),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule
`default_nettype wire
